// ===== hdl/pts_pkg.sv =====
// Package for the packet traffic statistics block: item types and constants.
// No dependencies.
`default_nettype none
package pts_pkg;
   localparam logic [15:0] MIN_ETHER_TWO = 16'd1536;
   localparam logic [15:0] TYPE_IPV4     = 16'h0800;
   localparam logic [7:0]  PROTO_ICMP    = 8'd1;
   localparam logic [7:0]  PROTO_TCP     = 8'd6;
   localparam logic [7:0]  PROTO_UDP     = 8'd17;

   localparam logic [2:0] KIND_NONE  = 3'd0;
   localparam logic [2:0] KIND_TCP   = 3'd1;
   localparam logic [2:0] KIND_UDP   = 3'd2;
   localparam logic [2:0] KIND_ICMP  = 3'd3;
   localparam logic [2:0] KIND_OTHER = 3'd4;

   localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
   localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [15:0] frame_length;
      logic [15:0] type_length;
      logic [7:0]  ip_protocol;
      logic [31:0] ip_source;
      logic [31:0] ip_destination;
      logic [15:0] source_port;
      logic [15:0] destination_port;
   } req_type;

   typedef struct packed {
      logic        ether_class;
      logic [31:0] ethertype_count;
      logic [47:0] ethertype_bytes;
      logic [31:0] address_pair_count;
      logic [2:0]  transport_kind;
      logic [31:0] port_pair_count;
      logic        table_full;
      logic [31:0] total_packets;
      logic [47:0] ethernet_two_bytes;
   } rsp_type;

   // Start command and outcome between the top level and a table unit.
   typedef struct packed {
      logic        start;
      logic [63:0] key;
      logic [47:0] add;
   } tbl_cmd_type;

   typedef struct packed {
      logic        done;
      logic        full;
      logic [31:0] count;
      logic [47:0] bytes;
   } tbl_res_type;

   function automatic logic [31:0] inc32(input logic [31:0] v);
      return (v == MAX32) ? v : v + 32'd1;
   endfunction

   function automatic logic [47:0] add48(input logic [47:0] v, input logic [47:0] a);
      logic [48:0] s;
      s = {1'b0, v} + {1'b0, a};
      return s[48] ? MAX48 : s[47:0];
   endfunction
endpackage
`default_nettype wire

// ===== hdl/pts_if.sv =====
// Valid/ready channel interfaces for request and response items.
// Depends on pts_pkg.
`default_nettype none
interface pts_req_if;
   logic              valid;
   logic              ready;
   pts_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface pts_rsp_if;
   logic              valid;
   logic              ready;
   pts_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/pts_table.sv =====
// One keyed counter table: a key memory, a count memory and a byte memory,
// scanned one entry per cycle, then updated in place. Depends on pts_pkg.
`default_nettype none
module pts_table #(
   parameter int ENTRIES   = 64,
   parameter int KEY_W     = 64,
   parameter bit HAS_BYTES = 1'b0
) (
   input  wire                  clock,
   input  wire                  reset,
   input  pts_pkg::tbl_cmd_type cmd,
   output pts_pkg::tbl_res_type res
);
   import pts_pkg::*;

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_READ, S_WRITE} state_type;

   logic [KEY_W-1:0] key_mem [ENTRIES];
   logic [31:0]      cnt_mem [ENTRIES];
   logic [47:0]      byt_mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;

   state_type        state_ff;
   logic [CW-1:0]    idx_ff;      // address being read
   logic [AW-1:0]    cmp_ff;      // address of data in key_rd_ff
   logic [KEY_W-1:0] key_rd_ff;
   logic [31:0]      cnt_rd_ff;
   logic [47:0]      byt_rd_ff;
   logic [KEY_W-1:0] key_ff;
   logic [47:0]      add_ff;
   logic             hit_ff, free_ok_ff;
   logic [AW-1:0]    slot_ff, free_ff;
   logic             cmp_valid;
   logic             match;
   logic [31:0]      new_cnt;
   logic [47:0]      new_byt;

   assign cmp_valid = valid_ff[cmp_ff];
   assign match     = cmp_valid && (key_rd_ff == key_ff);
   assign new_cnt   = inc32(hit_ff ? cnt_rd_ff : 32'd0);
   assign new_byt   = add48(hit_ff ? byt_rd_ff : 48'd0, add_ff);

   // Synchronous memory reads, and the write to the chosen slot.
   always_ff @(posedge clock) begin
      key_rd_ff <= key_mem[idx_ff[AW-1:0]];
      cnt_rd_ff <= cnt_mem[idx_ff[AW-1:0]];
      byt_rd_ff <= byt_mem[idx_ff[AW-1:0]];
      if (state_ff == S_WRITE && (hit_ff || free_ok_ff)) begin
         key_mem[slot_ff] <= key_ff;
         cnt_mem[slot_ff] <= new_cnt;
         if (HAS_BYTES) byt_mem[slot_ff] <= new_byt;
      end
   end

   // Scan, read back the chosen slot on a hit, then write.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         valid_ff   <= '0;
         res        <= '0;
         idx_ff     <= '0;
         cmp_ff     <= '0;
         hit_ff     <= 1'b0;
         free_ok_ff <= 1'b0;
         slot_ff    <= '0;
         free_ff    <= '0;
      end else begin
         res.done <= (state_ff == S_WRITE);
         case (state_ff)
            S_IDLE: begin
               if (cmd.start) begin
                  key_ff     <= cmd.key[KEY_W-1:0];
                  add_ff     <= cmd.add;
                  hit_ff     <= 1'b0;
                  free_ok_ff <= 1'b0;
                  idx_ff     <= CW'(1);
                  cmp_ff     <= '0;
                  state_ff   <= (ENTRIES == 1) ? S_LAST : S_SCAN;
               end
            end
            S_SCAN, S_LAST: begin
               if (match) begin
                  hit_ff   <= 1'b1;
                  slot_ff  <= cmp_ff;
                  idx_ff   <= CW'(cmp_ff);
                  state_ff <= S_READ;
               end else begin
                  if (!cmp_valid && !free_ok_ff) begin
                     free_ok_ff <= 1'b1;
                     free_ff    <= cmp_ff;
                  end
                  cmp_ff <= idx_ff[AW-1:0];
                  idx_ff <= idx_ff + CW'(1);
                  if (state_ff == S_LAST) begin
                     slot_ff  <= (!cmp_valid && !free_ok_ff) ? cmp_ff : free_ff;
                     state_ff <= S_WRITE;
                  end else if (idx_ff == CW'(ENTRIES - 1)) begin
                     state_ff <= S_LAST;
                  end
               end
            end
            S_READ: state_ff <= S_WRITE;
            S_WRITE: begin
               if (hit_ff || free_ok_ff) begin
                  valid_ff[slot_ff] <= 1'b1;
                  res.full  <= 1'b0;
                  res.count <= new_cnt;
                  res.bytes <= HAS_BYTES ? new_byt : 48'd0;
               end else begin
                  res.full  <= 1'b1;
                  res.count <= '0;
                  res.bytes <= '0;
               end
               idx_ff   <= '0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== hdl/packet_traffic_statistics.sv =====
// Packet traffic statistics: per-EtherType, IPv4 pair and TCP/UDP port pair
// counters. Depends on pts_pkg, pts_if and pts_table.
//
// Usage: one packet summary enters on the req channel (valid/ready) and one
// result item leaves on the rsp channel. Items are handled one at a time.
// The three lookups (EtherType, address pair, port pair) run side by side,
// each unit scanning its key memory one entry per cycle. A new item is accepted
// only once the result of the last one has been loaded into the output register.
// Tables not needed by an item stay idle. The result is held in an output
// register; a new item is accepted while it waits, but its result waits until
// the first is taken, so a stalled receiver holds the block with one result
// waiting and a second item finished behind it.
// Reset is synchronous and active high: all valid bits and global counters
// clear, so the block accepts items right after reset.
// A miss inserts the key in the lowest free slot; a full table reports
// table_full and a count of zero for that table.
`default_nettype none
module packet_traffic_statistics #(
   parameter int TYPE_ENTRIES = 16,
   parameter int PAIR_ENTRIES = 64,
   parameter int PORT_ENTRIES = 64
) (
   input wire     clock,
   input wire     reset,
   pts_req_if.sink   req,
   pts_rsp_if.source rsp
);
   import pts_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_WAIT, S_OUT} state_type;

   state_type   state_ff;
   req_type     item_ff;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;
   logic [31:0] total_ff, e2_pk_ff, lf_pk_ff, tcp_ff, udp_ff, icmp_ff;
   logic [47:0] e2_by_ff;
   logic        use_t_ff, use_a_ff, use_tcp_ff, use_udp_ff;
   logic        got_t_ff, got_a_ff, got_p_ff;
   tbl_res_type t_keep_ff, a_keep_ff, p_keep_ff;

   tbl_cmd_type t_cmd, a_cmd, tcp_cmd, udp_cmd;
   tbl_res_type t_res, a_res, tcp_res, udp_res, p_res;
   logic        accept, is_e2, is_ip;
   logic        all_done;
   logic        load_rsp;

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign is_e2     = req.data.type_length >= MIN_ETHER_TWO;
   assign is_ip     = req.data.type_length == TYPE_IPV4;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;
   assign load_rsp  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp.ready);

   // Start commands for the table units.
   always_comb begin
      t_cmd.start   = accept && is_e2;
      t_cmd.key     = {48'd0, req.data.type_length};
      t_cmd.add     = {32'd0, req.data.frame_length};
      a_cmd.start   = accept && is_ip;
      a_cmd.key     = {req.data.ip_source, req.data.ip_destination};
      a_cmd.add     = '0;
      tcp_cmd.start = accept && is_ip && req.data.ip_protocol == PROTO_TCP;
      tcp_cmd.key   = {32'd0, req.data.source_port, req.data.destination_port};
      tcp_cmd.add   = '0;
      udp_cmd       = tcp_cmd;
      udp_cmd.start = accept && is_ip && req.data.ip_protocol == PROTO_UDP;
      p_res         = use_tcp_ff ? tcp_res : udp_res;
   end

   pts_table #(.ENTRIES(TYPE_ENTRIES), .KEY_W(16), .HAS_BYTES(1'b1)) u_type (
      .clock(clock), .reset(reset), .cmd(t_cmd), .res(t_res));
   pts_table #(.ENTRIES(PAIR_ENTRIES), .KEY_W(64), .HAS_BYTES(1'b0)) u_pair (
      .clock(clock), .reset(reset), .cmd(a_cmd), .res(a_res));
   pts_table #(.ENTRIES(PORT_ENTRIES), .KEY_W(32), .HAS_BYTES(1'b0)) u_tcp (
      .clock(clock), .reset(reset), .cmd(tcp_cmd), .res(tcp_res));
   pts_table #(.ENTRIES(PORT_ENTRIES), .KEY_W(32), .HAS_BYTES(1'b0)) u_udp (
      .clock(clock), .reset(reset), .cmd(udp_cmd), .res(udp_res));

   assign all_done = (!use_t_ff || got_t_ff || t_res.done)
                  && (!use_a_ff || got_a_ff || a_res.done)
                  && (!(use_tcp_ff || use_udp_ff) || got_p_ff || p_res.done);

   // Item control, global counters and result assembly.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff <= '0; e2_pk_ff <= '0; lf_pk_ff <= '0; e2_by_ff <= '0;
         tcp_ff   <= '0; udp_ff   <= '0; icmp_ff  <= '0;
         use_t_ff <= 1'b0; use_a_ff <= 1'b0; use_tcp_ff <= 1'b0; use_udp_ff <= 1'b0;
         got_t_ff <= 1'b0; got_a_ff <= 1'b0; got_p_ff <= 1'b0;
      end else begin
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  item_ff    <= req.data;
                  use_t_ff   <= t_cmd.start;
                  use_a_ff   <= a_cmd.start;
                  use_tcp_ff <= tcp_cmd.start;
                  use_udp_ff <= udp_cmd.start;
                  got_t_ff <= 1'b0; got_a_ff <= 1'b0; got_p_ff <= 1'b0;
                  total_ff <= inc32(total_ff);
                  if (is_e2) begin
                     e2_pk_ff <= inc32(e2_pk_ff);
                     e2_by_ff <= add48(e2_by_ff, {32'd0, req.data.frame_length});
                  end else begin
                     lf_pk_ff <= inc32(lf_pk_ff);
                  end
                  if (is_ip) begin
                     case (req.data.ip_protocol)
                        PROTO_TCP:  tcp_ff  <= inc32(tcp_ff);
                        PROTO_UDP:  udp_ff  <= inc32(udp_ff);
                        PROTO_ICMP: icmp_ff <= inc32(icmp_ff);
                        default: ;
                     endcase
                  end
                  state_ff <= S_WAIT;
               end
            end
            S_WAIT: begin
               if (t_res.done) begin got_t_ff <= 1'b1; t_keep_ff <= t_res; end
               if (a_res.done) begin got_a_ff <= 1'b1; a_keep_ff <= a_res; end
               if (p_res.done) begin got_p_ff <= 1'b1; p_keep_ff <= p_res; end
               if (all_done) state_ff <= S_OUT;
            end
            S_OUT: begin
               if (load_rsp) begin
                  rsp_ff.ether_class        <= use_t_ff;
                  rsp_ff.ethertype_count    <= use_t_ff ? t_keep_ff.count : 32'd0;
                  rsp_ff.ethertype_bytes    <= use_t_ff ? t_keep_ff.bytes : 48'd0;
                  rsp_ff.address_pair_count <= use_a_ff ? a_keep_ff.count : 32'd0;
                  rsp_ff.port_pair_count    <= (use_tcp_ff || use_udp_ff) ?
                                               p_keep_ff.count : 32'd0;
                  rsp_ff.table_full <= (use_t_ff && t_keep_ff.full)
                                    || (use_a_ff && a_keep_ff.full)
                                    || ((use_tcp_ff || use_udp_ff) && p_keep_ff.full);
                  if (!use_a_ff)                  rsp_ff.transport_kind <= KIND_NONE;
                  else if (use_tcp_ff)            rsp_ff.transport_kind <= KIND_TCP;
                  else if (use_udp_ff)            rsp_ff.transport_kind <= KIND_UDP;
                  else if (item_ff.ip_protocol == PROTO_ICMP)
                                                  rsp_ff.transport_kind <= KIND_ICMP;
                  else                            rsp_ff.transport_kind <= KIND_OTHER;
                  rsp_ff.total_packets      <= total_ff;
                  rsp_ff.ethernet_two_bytes <= e2_by_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Counters kept as state but not reported per item.
   logic unused_cnt;
   assign unused_cnt = ^{e2_pk_ff, lf_pk_ff, tcp_ff, udp_ff, icmp_ff};
endmodule
`default_nettype wire

// ===== test/packet_traffic_statistics_test.sv =====
// Testbench for packet_traffic_statistics: directed table plus random packet summaries,
// checked field by field against typed-in results or a behavioral predictor of the tables.
// Depends on pts_pkg, pts_if and the block's RTL.
`timescale 1ns / 100ps
`default_nettype none
module packet_traffic_statistics_test;
   import pts_pkg::*;

   localparam int TYPE_SLOTS = 16;
   localparam int PAIR_SLOTS = 64;
   localparam int PORT_SLOTS = 64;
   localparam int RANDOM_ITEMS = 1300;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int unsigned cycle_count = 0;
   bit failed = 1'b0;

   pts_req_if req_ch ();
   pts_rsp_if rsp_ch ();

   packet_traffic_statistics DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Timeout guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("packet_traffic_statistics_test NOT OK");
         $finish;
      end
   end

   // Predictor state: a copy of every lookup table and of the two reported global counters.
   logic [15:0] ethertype_key [TYPE_SLOTS];
   logic [31:0] ethertype_packets [TYPE_SLOTS];
   logic [47:0] ethertype_octets [TYPE_SLOTS];
   bit          ethertype_used [TYPE_SLOTS];
   logic [63:0] pair_key [PAIR_SLOTS];
   logic [31:0] pair_packets [PAIR_SLOTS];
   bit          pair_used [PAIR_SLOTS];
   logic [31:0] tcp_key [PORT_SLOTS];
   logic [31:0] tcp_packets [PORT_SLOTS];
   bit          tcp_used [PORT_SLOTS];
   logic [31:0] udp_key [PORT_SLOTS];
   logic [31:0] udp_packets [PORT_SLOTS];
   bit          udp_used [PORT_SLOTS];
   logic [31:0] packets_seen = '0;
   logic [47:0] ether_two_octets = '0;

   rsp_type expected_stats [$];

   function automatic logic [31:0] bump(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic logic [47:0] accumulate(input logic [47:0] v, input logic [15:0] a);
      logic [48:0] sum;
      sum = {1'b0, v} + 49'(a);
      return sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0];
   endfunction

   // Updates the predictor tables for one packet and returns the expected result.
   function automatic rsp_type predict_stats(input req_type p);
      rsp_type o;
      int hit;
      int spare;
      logic [31:0] ports;
      o = '0;
      packets_seen = bump(packets_seen);
      if (p.type_length >= MIN_ETHER_TWO) begin
         o.ether_class = 1'b1;
         ether_two_octets = accumulate(ether_two_octets, p.frame_length);
         hit = -1;
         spare = -1;
         for (int i = 0; i < TYPE_SLOTS; i++) begin
            if (ethertype_used[i] && ethertype_key[i] == p.type_length && hit < 0) hit = i;
            if (!ethertype_used[i] && spare < 0) spare = i;
         end
         if (hit < 0 && spare >= 0) begin
            hit = spare;
            ethertype_used[hit] = 1'b1;
            ethertype_key[hit] = p.type_length;
            ethertype_packets[hit] = '0;
            ethertype_octets[hit] = '0;
         end
         if (hit >= 0) begin
            ethertype_packets[hit] = bump(ethertype_packets[hit]);
            ethertype_octets[hit] = accumulate(ethertype_octets[hit], p.frame_length);
            o.ethertype_count = ethertype_packets[hit];
            o.ethertype_bytes = ethertype_octets[hit];
         end else begin
            o.table_full = 1'b1;
         end
      end
      if (p.type_length == TYPE_IPV4) begin
         hit = -1;
         spare = -1;
         for (int i = 0; i < PAIR_SLOTS; i++) begin
            if (pair_used[i] && pair_key[i] == {p.ip_source, p.ip_destination} && hit < 0)
               hit = i;
            if (!pair_used[i] && spare < 0) spare = i;
         end
         if (hit < 0 && spare >= 0) begin
            hit = spare;
            pair_used[hit] = 1'b1;
            pair_key[hit] = {p.ip_source, p.ip_destination};
            pair_packets[hit] = '0;
         end
         if (hit >= 0) begin
            pair_packets[hit] = bump(pair_packets[hit]);
            o.address_pair_count = pair_packets[hit];
         end else begin
            o.table_full = 1'b1;
         end
         ports = {p.source_port, p.destination_port};
         if (p.ip_protocol == PROTO_TCP || p.ip_protocol == PROTO_UDP) begin
            hit = -1;
            spare = -1;
            o.transport_kind = (p.ip_protocol == PROTO_TCP) ? KIND_TCP : KIND_UDP;
            // The TCP and UDP port tables are searched the same way.
            for (int i = 0; i < PORT_SLOTS; i++) begin
               if (p.ip_protocol == PROTO_TCP) begin
                  if (tcp_used[i] && tcp_key[i] == ports && hit < 0) hit = i;
                  if (!tcp_used[i] && spare < 0) spare = i;
               end else begin
                  if (udp_used[i] && udp_key[i] == ports && hit < 0) hit = i;
                  if (!udp_used[i] && spare < 0) spare = i;
               end
            end
            if (hit < 0 && spare >= 0) begin
               hit = spare;
               if (p.ip_protocol == PROTO_TCP) begin
                  tcp_used[hit] = 1'b1;
                  tcp_key[hit] = ports;
                  tcp_packets[hit] = '0;
               end else begin
                  udp_used[hit] = 1'b1;
                  udp_key[hit] = ports;
                  udp_packets[hit] = '0;
               end
            end
            if (hit < 0) begin
               o.table_full = 1'b1;
            end else if (p.ip_protocol == PROTO_TCP) begin
               tcp_packets[hit] = bump(tcp_packets[hit]);
               o.port_pair_count = tcp_packets[hit];
            end else begin
               udp_packets[hit] = bump(udp_packets[hit]);
               o.port_pair_count = udp_packets[hit];
            end
         end else if (p.ip_protocol == PROTO_ICMP) begin
            o.transport_kind = KIND_ICMP;
         end else begin
            o.transport_kind = KIND_OTHER;
         end
      end
      o.total_packets = packets_seen;
      o.ethernet_two_bytes = ether_two_octets;
      return o;
   endfunction

   function automatic req_type packet(input logic [15:0] flen, input logic [15:0] etype,
                                      input logic [7:0] proto, input logic [31:0] src,
                                      input logic [31:0] dst, input logic [15:0] sport,
                                      input logic [15:0] dport);
      return '{flen, etype, proto, src, dst, sport, dport};
   endfunction

   function automatic rsp_type outcome(input logic cls, input logic [31:0] tcount,
                                       input logic [47:0] tbytes, input logic [31:0] acount,
                                       input logic [2:0] kind, input logic [31:0] pcount,
                                       input logic full, input logic [31:0] total,
                                       input logic [47:0] e2bytes);
      return '{cls, tcount, tbytes, acount, kind, pcount, full, total, e2bytes};
   endfunction

   // Directed stimulus: a packet and, where it is obvious, the result typed in.
   typedef struct {
      req_type stim;
      bit      typed;
      rsp_type want;
   } directed_row;

   directed_row rows [$];

   // Pools of addresses and ports so that lookups hit often and tables still fill.
   logic [31:0] address_pool [10];
   logic [15:0] port_pool [10];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   function automatic req_type random_packet();
      req_type p;
      logic [159:0] noise;
      int pick;
      int proto_pick;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
      p = req_type'(noise[135:0]);
      pick = $urandom_range(99);
      if (pick < 10) begin
         // Fully random noise item.
         return p;
      end else if (pick < 20) begin
         p.type_length = 16'($urandom_range(1535));
      end else if (pick < 30) begin
         p.type_length = 16'($urandom_range(16'hFFFF, 1536));
      end else begin
         p.type_length = TYPE_IPV4;
         p.ip_source = address_pool[$urandom_range(9)];
         p.ip_destination = address_pool[$urandom_range(9)];
         p.source_port = port_pool[$urandom_range(7)];
         p.destination_port = port_pool[$urandom_range(9)];
         proto_pick = $urandom_range(99);
         if (proto_pick < 35) p.ip_protocol = PROTO_TCP;
         else if (proto_pick < 70) p.ip_protocol = PROTO_UDP;
         else if (proto_pick < 80) p.ip_protocol = PROTO_ICMP;
      end
      return p;
   endfunction

   // Offers one item, waiting out the sender's idle cycles first.
   task automatic offer_item(input req_type p, input bit typed, input rsp_type want);
      rsp_type predicted;
      int gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= p;
      do @(posedge clock); while (!req_ch.ready);
      predicted = predict_stats(p);
      expected_stats.push_back(typed ? want : predicted);
   endtask

   // Result checking and receiver stalls.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type exp;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.data;
         if (expected_stats.size() == 0) begin
            $error("result item with nothing expected");
            failed = 1'b1;
         end else begin
            exp = expected_stats.pop_front();
            if (got.ether_class !== exp.ether_class) begin
               $error("ether_class expected %0d got %0d", exp.ether_class, got.ether_class);
               failed = 1'b1;
            end
            if (got.ethertype_count !== exp.ethertype_count) begin
               $error("ethertype_count expected %0d got %0d",
                      exp.ethertype_count, got.ethertype_count);
               failed = 1'b1;
            end
            if (got.ethertype_bytes !== exp.ethertype_bytes) begin
               $error("ethertype_bytes expected %0d got %0d",
                      exp.ethertype_bytes, got.ethertype_bytes);
               failed = 1'b1;
            end
            if (got.address_pair_count !== exp.address_pair_count) begin
               $error("address_pair_count expected %0d got %0d",
                      exp.address_pair_count, got.address_pair_count);
               failed = 1'b1;
            end
            if (got.transport_kind !== exp.transport_kind) begin
               $error("transport_kind expected %0d got %0d",
                      exp.transport_kind, got.transport_kind);
               failed = 1'b1;
            end
            if (got.port_pair_count !== exp.port_pair_count) begin
               $error("port_pair_count expected %0d got %0d",
                      exp.port_pair_count, got.port_pair_count);
               failed = 1'b1;
            end
            if (got.table_full !== exp.table_full) begin
               $error("table_full expected %0d got %0d", exp.table_full, got.table_full);
               failed = 1'b1;
            end
            if (got.total_packets !== exp.total_packets) begin
               $error("total_packets expected %0d got %0d",
                      exp.total_packets, got.total_packets);
               failed = 1'b1;
            end
            if (got.ethernet_two_bytes !== exp.ethernet_two_bytes) begin
               $error("ethernet_two_bytes expected %0d got %0d",
                      exp.ethernet_two_bytes, got.ethernet_two_bytes);
               failed = 1'b1;
            end
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Main sequence.
   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      for (int i = 0; i < TYPE_SLOTS; i++) ethertype_used[i] = 1'b0;
      for (int i = 0; i < PAIR_SLOTS; i++) pair_used[i] = 1'b0;
      for (int i = 0; i < PORT_SLOTS; i++) begin
         tcp_used[i] = 1'b0;
         udp_used[i] = 1'b0;
      end
      address_pool[0] = 32'h0000_0000;
      address_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 10; i++) address_pool[i] = $urandom;
      port_pool[0] = 16'h0000;
      port_pool[1] = 16'hFFFF;
      for (int i = 2; i < 10; i++) port_pool[i] = 16'($urandom);

      // Boundary of frame classes, IPv4 transports, extremes of every field.
      rows.push_back('{packet(16'hFFFF, 16'h05FF, PROTO_TCP, '1, '1, '1, '1), 1'b1,
                       outcome(1'b0, 32'd0, 48'd0, 32'd0, KIND_NONE, 32'd0, 1'b0,
                               32'd1, 48'd0)});
      rows.push_back('{packet(16'hFFFF, 16'h0600, 8'h00, '0, '0, '0, '0), 1'b1,
                       outcome(1'b1, 32'd1, 48'd65535, 32'd0, KIND_NONE, 32'd0, 1'b0,
                               32'd2, 48'd65535)});
      rows.push_back('{packet(16'h0000, 16'hFFFF, 8'hFF, '0, '0, '0, '0), 1'b1,
                       outcome(1'b1, 32'd1, 48'd0, 32'd0, KIND_NONE, 32'd0, 1'b0,
                               32'd3, 48'd65535)});
      rows.push_back('{packet(16'd64, TYPE_IPV4, PROTO_TCP, '0, '1, 16'hFFFF, 16'h0000), 1'b1,
                       outcome(1'b1, 32'd1, 48'd64, 32'd1, KIND_TCP, 32'd1, 1'b0,
                               32'd4, 48'd65599)});
      rows.push_back('{packet(16'd64, TYPE_IPV4, PROTO_TCP, '0, '1, 16'hFFFF, 16'h0000), 1'b1,
                       outcome(1'b1, 32'd2, 48'd128, 32'd2, KIND_TCP, 32'd2, 1'b0,
                               32'd5, 48'd65663)});
      rows.push_back('{packet(16'd64, TYPE_IPV4, PROTO_UDP, '0, '1, 16'hFFFF, 16'h0000),
                       1'b0, '0});
      rows.push_back('{packet(16'd100, TYPE_IPV4, PROTO_UDP, '1, '0, 16'h0000, 16'hFFFF),
                       1'b0, '0});
      rows.push_back('{packet(16'd100, TYPE_IPV4, PROTO_TCP, '1, '0, 16'h0000, 16'hFFFF),
                       1'b0, '0});
      rows.push_back('{packet(16'd42, TYPE_IPV4, PROTO_ICMP, '0, '1, '1, '1), 1'b0, '0});
      rows.push_back('{packet(16'd60, TYPE_IPV4, 8'h00, 32'h0A00_0001, '1, '0, '0), 1'b0, '0});
      rows.push_back('{packet(16'd60, TYPE_IPV4, 8'hFF, 32'h0A00_0001, '1, '0, '0), 1'b0, '0});
      rows.push_back('{packet(16'd60, 16'h0801, PROTO_TCP, '0, '1, '1, '0), 1'b0, '0});
      rows.push_back('{packet(16'h8000, 16'h0000, PROTO_UDP, '1, '1, '1, '1), 1'b0, '0});
      rows.push_back('{packet(16'hFFFF, TYPE_IPV4, PROTO_UDP, '1, '0, 16'h0000, 16'hFFFF),
                       1'b0, '0});

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Sender idles lightly, receiver stalls heavily.
      sender_idle_pct = 9;
      receiver_stall_pct = 64;
      foreach (rows[i]) offer_item(rows[i].stim, rows[i].typed, rows[i].want);
      for (int i = 0; i < RANDOM_ITEMS / 3; i++) offer_item(random_packet(), 1'b0, '0);

      // Roles swapped.
      sender_idle_pct = 64;
      receiver_stall_pct = 9;
      for (int i = 0; i < RANDOM_ITEMS / 3; i++) offer_item(random_packet(), 1'b0, '0);

      // No idling on either side.
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      for (int i = 0; i < RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3); i++)
         offer_item(random_packet(), 1'b0, '0);
      req_ch.valid <= 1'b0;

      while (expected_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed) begin
         $display("packet_traffic_statistics_test OK");
      end else begin
         $display("packet_traffic_statistics_test NOT OK");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
hdl/pts_pkg.sv
hdl/pts_if.sv
hdl/pts_table.sv
hdl/packet_traffic_statistics.sv
test/packet_traffic_statistics_test.sv
